### src/rmst_pkg.sv
// ============================================================================
// rmst_pkg: shared types and constants for the range minimum segment tree
// Field widths, node encoding, controller states and the command and status
// groups that pass between the controller and the datapath.
// ============================================================================
package rmst_pkg;

   localparam int CMD_W   = 1;
   localparam int IDX_W   = 10;
   localparam int VALUE_W = 32;

   // Nodes hold value XOR SIGN_FLIP so that unsigned order matches signed order.
   localparam logic [VALUE_W-1:0] SIGN_FLIP  = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] BIASED_MAX = 32'hFFFF_FFFF;

   localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR_UP,
      ST_Q_WALK,
      ST_Q_DRAIN,
      ST_Q_DONE
   } state_type;

   typedef struct packed {
      logic clr_step;
      logic ld_write;
      logic up_step;
      logic ld_query;
      logic walk_step;
      logic load_rsp;
   } ctrl_type;

   typedef struct packed {
      logic clr_last;
      logic up_last;
      logic walk_last;
      logic skip;
      logic empty;
      logic rsp_busy;
   } status_type;

endpackage

### src/rmst_ctrl.sv
// ============================================================================
// rmst_ctrl: sequencing state machine
// Runs the clearing pass, the leaf-to-root update of a write and the
// two-pointer walk of a query, and hands the result to the output register.
// ============================================================================
module rmst_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_cmd,
   input  rmst_pkg::status_type status,
   output rmst_pkg::ctrl_type   ctrl
);
   import rmst_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = req_tvalid && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_cmd == CMD_WRITE) begin
                  state_in = status.skip ? ST_IDLE : ST_WR_UP;
               end else begin
                  state_in = status.empty ? ST_Q_DONE : ST_Q_WALK;
               end
            end
         end
         ST_WR_UP: begin
            if (status.up_last) state_in = ST_IDLE;
         end
         ST_Q_WALK: begin
            if (status.walk_last) state_in = ST_Q_DRAIN;
         end
         ST_Q_DRAIN: begin
            state_in = ST_Q_DONE;
         end
         ST_Q_DONE: begin
            if (!status.rsp_busy) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      ctrl       = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ctrl.clr_step = 1'b1;
         end
         ST_IDLE: begin
            req_tready    = 1'b1;
            ctrl.ld_write = accept && (req_cmd == CMD_WRITE) && !status.skip;
            ctrl.ld_query = accept && (req_cmd == CMD_QUERY);
         end
         ST_WR_UP: begin
            ctrl.up_step = 1'b1;
         end
         ST_Q_WALK: begin
            ctrl.walk_step = 1'b1;
         end
         ST_Q_DRAIN: begin
            ctrl = '0;
         end
         ST_Q_DONE: begin
            ctrl.load_rsp = !status.rsp_busy;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

endmodule

### src/rmst_datapath.sv
// ============================================================================
// rmst_datapath: node memory, walk pointers and minimum logic
// Holds the tree as one memory with a write port and two read ports, the
// update and query pointers, the running minimum and the result register.
// ============================================================================
module rmst_datapath #(
   parameter int ENTRIES = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [rmst_pkg::IDX_W-1:0]          req_index,
   input  logic [rmst_pkg::VALUE_W-1:0]        req_value,
   input  logic [rmst_pkg::IDX_W-1:0]          req_range_low,
   input  logic [rmst_pkg::IDX_W-1:0]          req_range_high,
   input  rmst_pkg::ctrl_type                   ctrl,
   output rmst_pkg::status_type                 status,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rmst_pkg::VALUE_W-1:0]        rsp_min_value
);
   import rmst_pkg::*;

   localparam int NW = $clog2(2 * ENTRIES);
   localparam int PW = NW + 1;
   localparam int XW = ((PW > IDX_W) ? PW : IDX_W) + 1;
   localparam logic [XW-1:0] ENTRIES_X = XW'(ENTRIES);
   localparam logic [NW-1:0] LAST_NODE = NW'(2 * ENTRIES - 1);
   localparam logic [NW-1:0] ROOT      = NW'(1);

   logic [VALUE_W-1:0] mem [0:2*ENTRIES-1];

   logic [NW-1:0]      p_ff, p_in;
   logic [VALUE_W-1:0] cur_ff, cur_in;
   logic [PW-1:0]      l_ff, l_in, r_ff, r_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               take_l_ff, take_l_in, take_r_ff, take_r_in;
   logic [NW-1:0]      clr_ff, clr_in;
   logic [VALUE_W-1:0] rd0_ff, rd1_ff;
   logic [VALUE_W-1:0] rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               wr_en;
   logic [NW-1:0]      wr_addr, rd0_addr, rd1_addr;
   logic [VALUE_W-1:0] wr_data;

   logic [XW-1:0]      idx_x, lo_x, hi_x, hi_sat;
   logic [NW-1:0]      leaf, p_half;
   logic [VALUE_W-1:0] up_min, cand_l, cand_r, acc_lr;

   // Range checks on the incoming request, its leaf address and the update and walk minimum selects.
   always_comb begin
      idx_x  = XW'(req_index);
      lo_x   = XW'(req_range_low);
      hi_x   = XW'(req_range_high);
      hi_sat = (hi_x >= ENTRIES_X) ? (ENTRIES_X - XW'(1)) : hi_x;
      leaf   = NW'(idx_x + ENTRIES_X);
      p_half = p_ff >> 1;
      up_min = (rd0_ff < cur_ff) ? rd0_ff : cur_ff;
      cand_l = take_l_ff ? rd0_ff : BIASED_MAX;
      cand_r = take_r_ff ? rd1_ff : BIASED_MAX;
      acc_lr = (cand_l < cand_r) ? cand_l : cand_r;
   end

   always_comb begin
      p_in      = p_ff;
      cur_in    = cur_ff;
      l_in      = l_ff;
      r_in      = r_ff;
      clr_in    = clr_ff;
      take_l_in = 1'b0;
      take_r_in = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = p_half;
      wr_data   = up_min;
      rd0_addr  = p_half ^ ROOT;
      rd1_addr  = NW'(r_ff - PW'(1));
      acc_in    = (acc_lr < acc_ff) ? acc_lr : acc_ff;

      if (ctrl.clr_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = BIASED_MAX;
         clr_in  = clr_ff + NW'(1);
      end
      if (ctrl.ld_write) begin
         wr_en    = 1'b1;
         wr_addr  = leaf;
         wr_data  = req_value ^ SIGN_FLIP;
         rd0_addr = leaf ^ ROOT;
         p_in     = leaf;
         cur_in   = req_value ^ SIGN_FLIP;
      end
      if (ctrl.up_step) begin
         // Parent takes the smaller of the path value and its sibling.
         wr_en  = 1'b1;
         p_in   = p_half;
         cur_in = up_min;
      end
      if (ctrl.ld_query) begin
         l_in   = PW'(lo_x + ENTRIES_X);
         r_in   = PW'(hi_sat + ENTRIES_X + XW'(1));
         acc_in = BIASED_MAX;
      end
      if (ctrl.walk_step) begin
         // An odd left edge takes that node, an odd right bound takes the node below it; both move inward.
         rd0_addr  = NW'(l_ff);
         take_l_in = l_ff[0];
         take_r_in = r_ff[0];
         l_in      = (l_ff + PW'(l_ff[0])) >> 1;
         r_in      = (r_ff - PW'(r_ff[0])) >> 1;
      end
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (ctrl.load_rsp) begin
         rsp_data_in  = acc_ff ^ SIGN_FLIP;
         rsp_valid_in = 1'b1;
      end
   end

   always_comb begin
      status.clr_last  = (clr_ff == LAST_NODE);
      status.up_last   = (p_half == ROOT);
      status.walk_last = (l_in >= r_in);
      status.skip      = (idx_x >= ENTRIES_X);
      status.empty     = (lo_x > hi_sat);
      status.rsp_busy  = rsp_valid_ff && !rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd0_ff <= mem[rd0_addr];
      rd1_ff <= mem[rd1_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         take_l_ff    <= 1'b0;
         take_r_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         take_l_ff    <= take_l_in;
         take_r_ff    <= take_r_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff        <= p_in;
      cur_ff      <= cur_in;
      l_ff        <= l_in;
      r_ff        <= r_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_min_value = rsp_data_ff;

endmodule

### src/range_min_segment_tree_top.sv
// ============================================================================
// range_min_segment_tree_top: range minimum segment tree with point writes
// Channel  Dir  Handshake          Payload
// req      in   req_tvalid/tready  tuser: cmd; tdata: index, value, range_low,
//                                  range_high
// rsp      out  rsp_tvalid/tready  tdata: min_value
// A write writes the leaf in the accept cycle, then one parent per cycle up to
// the root. A query runs accept, one walk step per level, a drain state and
// the result load, which waits on a stalled output; an empty range skips the walk.
// After reset a clearing pass writes all 2*ENTRIES nodes with req_tready low.
// A result waits in the output register while the next request is accepted;
// a query finishes only once that register is free.
// ============================================================================
module range_min_segment_tree_top #(
   parameter int ENTRIES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [0:0]  req_tuser,  // [0] cmd
   // [9:0] index, [41:10] value, [51:42] range_low, [61:52] range_high, [63:62] zero
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // [31:0] min_value
);
   import rmst_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   rmst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser[0]),
      .status     (status),
      .ctrl       (ctrl)
   );

   rmst_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_index      (req_tdata[9:0]),
      .req_value      (req_tdata[41:10]),
      .req_range_low  (req_tdata[51:42]),
      .req_range_high (req_tdata[61:52]),
      .ctrl           (ctrl),
      .status         (status),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_min_value  (rsp_tdata)
   );

endmodule

### src/rmst_checker.sv
// ============================================================================
// rmst_checker: port-level checks for the range minimum segment tree
// Watches the request and response handshakes of the top level.
// ============================================================================
module rmst_checker #(
   parameter int ENTRIES = 1024
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [0:0]  req_tuser,
   input logic [63:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);
   import rmst_pkg::*;

   logic req_fire;
   logic busy_item;

   assign req_fire  = req_tvalid && req_tready;
   assign busy_item = (req_tuser[0] == CMD_QUERY) || (32'(req_tdata[9:0]) < 32'(ENTRIES));

   // A stalled response keeps its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response data changed while stalled");

   // The clearing pass keeps requests out right after reset.
   a_clear_busy: assert property (@(posedge clock)
      $past(reset) |-> !req_tready)
      else $error("request ready during clearing pass");

   // Any request that does tree work makes the block busy next cycle.
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      req_fire && busy_item |=> !req_tready)
      else $error("block ready right after accepting work");

   // A new response appears only after a query finishes, never from the idle state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response appeared while block was idle");

endmodule

bind range_min_segment_tree_top rmst_checker #(
   .ENTRIES (ENTRIES)
) u_rmst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
